// ===== src/http_chunked_decoder_macros.svh =====
// Assertion helpers for the chunked decoder
`ifndef HTTP_CHUNKED_DECODER_MACROS_SVH
`define HTTP_CHUNKED_DECODER_MACROS_SVH

// Same-cycle implication, off during reset
`define HCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define HCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hcd_pkg.sv =====
package hcd_pkg;

  localparam int SIZE_BITS_DEF = 24;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  typedef enum logic [5:0] {
    PH_SIZE    = 6'b000001,
    PH_SIZE_LF = 6'b000010,
    PH_DATA    = 6'b000100,
    PH_DATA_CR = 6'b001000,
    PH_DATA_LF = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic       error;
  } hcd_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decode one ASCII hex digit, either case
  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== src/hcd_parser.sv =====
module hcd_parser #(
  parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [7:0]        in_byte,
  output hcd_pkg::hcd_res_t res
);
  import hcd_pkg::*;

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next;
  logic                 final_chunk, final_chunk_next;
  logic                 error_flag, error_flag_next;
  hex_t                 hex;

  assign hex = hex_decode(in_byte);

  always_comb begin
    phase_next       = phase;
    size_accum_next  = size_accum;
    bytes_left_next  = bytes_left;
    final_chunk_next = final_chunk;
    error_flag_next  = error_flag;
    res              = '0;
    if (!error_flag) begin
      case (phase)
        PH_SIZE: begin
          if (in_byte == BYTE_CR) begin
            phase_next = PH_SIZE_LF;
          end else if (!hex.ok || size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
            error_flag_next = 1'b1;
          end else begin
            size_accum_next = {size_accum[SIZE_BITS-5:0], hex.val};
          end
        end
        PH_SIZE_LF: begin
          if (in_byte != BYTE_LF) begin
            error_flag_next = 1'b1;
          end else if (size_accum == '0) begin
            final_chunk_next = 1'b1;
            phase_next       = PH_DATA_CR;
          end else begin
            bytes_left_next = size_accum;
            phase_next      = PH_DATA;
          end
        end
        PH_DATA: begin
          res.data_valid  = 1'b1;
          res.data_byte   = in_byte;
          bytes_left_next = bytes_left - 1'b1;
          if (bytes_left_next == '0) phase_next = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (in_byte == BYTE_CR) phase_next = PH_DATA_LF;
          else error_flag_next = 1'b1;
        end
        PH_DATA_LF: begin
          if (in_byte != BYTE_LF) begin
            error_flag_next = 1'b1;
          end else if (final_chunk) begin
            res.done_res = 1'b1;
            phase_next   = PH_DONE;
          end else begin
            size_accum_next = '0;
            phase_next      = PH_SIZE;
          end
        end
        default: begin
          // anything after done, or a corrupt phase
          error_flag_next = 1'b1;
        end
      endcase
    end
    res.error = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SIZE;
      size_accum  <= '0;
      bytes_left  <= '0;
      final_chunk <= 1'b0;
      error_flag  <= 1'b0;
    end else if (en) begin
      phase       <= phase_next;
      size_accum  <= size_accum_next;
      bytes_left  <= bytes_left_next;
      final_chunk <= final_chunk_next;
      error_flag  <= error_flag_next;
    end
  end

endmodule

// ===== src/http_chunked_decoder.sv =====
// Path: an accepted input beat passes the input register and then the result register on its way to its result beat.
// Throughput: one byte per cycle while the output is not stalled; the parser's next state and result
// are computed combinationally between the input register and the result register.
// Reset: synchronous, active high; parser returns to the size digits phase with
// size, count, final and error flags cleared; both pipeline registers emptied.
`include "http_chunked_decoder_macros.svh"

module http_chunked_decoder #(
  parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       data_valid,
  output logic [7:0] data_byte,
  output logic       done_res,
  output logic       error
);
  import hcd_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_ready;
  logic       s1_adv;
  hcd_res_t   res;
  hcd_res_t   out_res;

  assign out_ready = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_byte <= in_byte;
  end

  hcd_parser #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .en     (s1_adv),
    .in_byte(s1_byte),
    .res    (res)
  );

  // result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_res <= res;
  end

  assign data_valid = out_res.data_valid;
  assign data_byte  = out_res.data_byte;
  assign done_res   = out_res.done_res;
  assign error      = out_res.error;

  `HCD_ASSERT_NEXT(a_err_sticky, clk, rst, out_valid && error, !out_valid || error, "error flag dropped")
  `HCD_ASSERT_NOW(a_err_quiet, clk, rst, out_valid && error, !data_valid && !done_res, "beat after error carries data or done")
  `HCD_ASSERT_NOW(a_done_no_data, clk, rst, out_valid && data_valid, !done_res, "payload beat flagged done")
  `HCD_ASSERT_NOW(a_stall_full, clk, rst, in_stall, s1_valid, "input stalled with empty input register")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import hcd_pkg::*;

  localparam int SZ = SIZE_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BEATS = 1500;

  typedef enum int {
    END_TRAILING,
    END_TRAILER,
    END_BAD_HEX,
    END_OVERFLOW,
    END_SIZE_NO_LF,
    END_DATA_NO_CR,
    END_DATA_NO_LF
  } end_kind_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       done_res;
  logic       res_error;

  // decoder state as predicted from the beats sent so far
  phase_t        parse_ph;
  logic [SZ-1:0] size_acc;
  logic [SZ-1:0] left;
  logic          last_chunk;
  logic          err_flag;

  hcd_res_t    expected_q[$];
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned stall_left;
  bit          idle_on;

  http_chunked_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_valid (data_valid),
    .data_byte  (data_byte),
    .done_res   (done_res),
    .error      (res_error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // 16 marks a byte that is not a hex digit
  function automatic logic [4:0] digit_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 9))
      0: return BYTE_CR;
      1: return BYTE_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic decode_step(input logic [7:0] b);
    hcd_res_t   r;
    logic [4:0] v;
    r = '0;
    if (!err_flag) begin
      case (parse_ph)
        PH_SIZE: begin
          if (b == BYTE_CR) begin
            parse_ph = PH_SIZE_LF;
          end else begin
            v = digit_value(b);
            if (v[4] || size_acc[SZ-1 -: 4] != '0) err_flag = 1'b1;
            else size_acc = {size_acc[SZ-5:0], v[3:0]};
          end
        end
        PH_SIZE_LF: begin
          if (b != BYTE_LF) begin
            err_flag = 1'b1;
          end else if (size_acc == '0) begin
            last_chunk = 1'b1;
            parse_ph = PH_DATA_CR;
          end else begin
            left = size_acc;
            parse_ph = PH_DATA;
          end
        end
        PH_DATA: begin
          r.data_valid = 1'b1;
          r.data_byte = b;
          left = left - 1'b1;
          if (left == '0) parse_ph = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (b == BYTE_CR) parse_ph = PH_DATA_LF;
          else err_flag = 1'b1;
        end
        PH_DATA_LF: begin
          if (b != BYTE_LF) begin
            err_flag = 1'b1;
          end else if (last_chunk) begin
            r.done_res = 1'b1;
            parse_ph = PH_DONE;
          end else begin
            size_acc = '0;
            parse_ph = PH_SIZE;
          end
        end
        default: err_flag = 1'b1;
      endcase
    end
    r.error = err_flag;
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    decode_step(b);
  endtask

  task automatic send_size_line(input int unsigned size, input int unsigned zeros);
    logic [3:0]  nib[$];
    int unsigned s;
    s = size;
    while (s != 0) begin
      nib.push_front(4'(s & 15));
      s = s >> 4;
    end
    repeat (zeros) send_byte(8'h30);
    foreach (nib[i]) send_byte(digit_char(nib[i]));
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
  endtask

  task automatic send_chunk(input int unsigned size, input int unsigned zeros);
    send_size_line(size, zeros);
    repeat (size) send_byte(payload_byte());
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
  endtask

  // empty, single zero, or padded zeros all close the message
  task automatic send_last_size_line();
    case ($urandom_range(0, 2))
      0: send_size_line(0, 0);
      1: send_size_line(0, 1);
      default: send_size_line(0, $urandom_range(2, 5));
    endcase
  endtask

  task automatic test_directed();
    // padded size line, payload holding the byte extremes and bare CR / LF
    send_size_line(1, 0);
    send_byte(8'h00);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_size_line(2, 7);
    send_byte(8'hFF);
    send_byte(BYTE_CR);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_size_line(3, 0);
    send_byte(BYTE_LF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
  endtask

  task automatic test_wide_size_line();
    // six digits each: leading zeros pad the size to the accumulator's digit width
    send_chunk(32'h100, 3);
    send_chunk(32'hFE, 4);
  endtask

  task automatic test_random_chunks();
    int unsigned size;
    while (beats_sent < RANDOM_BEATS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 39) == 0) size = $urandom_range(41, 255);
      else size = $urandom_range(1, 40);
      send_chunk(size, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    end
  endtask

  task automatic test_termination();
    end_kind_t   kind;
    logic [7:0]  b;
    idle_on = 1'b0;
    if ($urandom_range(0, 1)) kind = END_TRAILING;
    else kind = end_kind_t'($urandom_range(END_TRAILER, END_DATA_NO_LF));
    case (kind)
      END_TRAILING: begin
        send_last_size_line();
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
      end
      END_TRAILER: begin
        send_last_size_line();
        do b = 8'($urandom_range(0, 255)); while (b == BYTE_CR);
        send_byte(b);
      end
      END_BAD_HEX: begin
        send_byte(digit_char(4'($urandom_range(0, 15))));
        if ($urandom_range(0, 1)) begin
          b = 8'h3B;  // chunk extension
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (digit_value(b) != 5'd16 || b == BYTE_CR);
        end
        send_byte(b);
      end
      END_OVERFLOW: begin
        send_byte(8'h31);
        repeat (6) send_byte(digit_char(4'($urandom_range(0, 15))));
      end
      END_SIZE_NO_LF: begin
        send_byte(digit_char(4'($urandom_range(1, 15))));
        send_byte(BYTE_CR);
        do b = 8'($urandom_range(0, 255)); while (b == BYTE_LF);
        send_byte(b);
      end
      END_DATA_NO_CR: begin
        send_size_line(2, 0);
        repeat (2) send_byte(payload_byte());
        do b = 8'($urandom_range(0, 255)); while (b == BYTE_CR);
        send_byte(b);
      end
      default: begin
        send_size_line(2, 0);
        repeat (2) send_byte(payload_byte());
        send_byte(BYTE_CR);
        do b = 8'($urandom_range(0, 255)); while (b == BYTE_LF);
        send_byte(b);
      end
    endcase
    // everything after the fault must hold the sticky error
    repeat (16) send_byte(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    hcd_res_t got;
    hcd_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{data_valid, data_byte, done_res, res_error};
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d arrived with none expected", results_seen);
        end else begin
          want = expected_q.pop_front();
          if (got.data_valid !== want.data_valid || got.data_byte !== want.data_byte ||
              got.done_res !== want.done_res || got.error !== want.error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected valid=%b byte=%h done=%b err=%b, got %b %h %b %b",
                       results_seen, want.data_valid, want.data_byte, want.done_res,
                       want.error, got.data_valid, got.data_byte, got.done_res, got.error);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_byte   <= 8'h00;
    parse_ph   = PH_SIZE;
    size_acc   = '0;
    left       = '0;
    last_chunk = 1'b0;
    err_flag   = 1'b0;
    idle_on    = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_wide_size_line();
    test_random_chunks();
    test_termination();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/hcd_pkg.sv
src/hcd_parser.sv
src/http_chunked_decoder.sv
tb/tb_top.sv
